// ===== design/wasm_pkg.sv =====
package wasm_pkg;

    localparam int BYTE_W     = 8;
    localparam int OFFSET_W   = 16;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int LEN_W      = 5;
    localparam int MODE_W     = 2;
    localparam int NEEDLE_SLOTS = 16;
    localparam int SLOT_IDX_W   = 4;

    localparam int DEF_MAX_NEEDLE_BYTES = 16;
    localparam int DEF_MAX_LINE_BYTES   = 65536;

    localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;

    localparam int MODE_FOLD_BIT  = 0;
    localparam int MODE_WHOLE_BIT = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEEDLE_LOW  = 2'd0,
        CFG_NEEDLE_HIGH = 2'd1,
        CFG_NEEDLE_LEN  = 2'd2,
        CFG_MATCH_MODE  = 2'd3
    } t_cfg_reg;

    // per-beat control fanned out to every window cell
    typedef struct packed {
        logic shift;
        logic clear;
        logic fold;
    } t_cell_ctrl;

    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c,
                                                    input logic fold);
        logic [BYTE_W-1:0] r;
        r = c;
        if (fold && c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== design/wasm_in_if.sv =====
interface wasm_in_if;
    import wasm_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] haystack_byte;
    logic              end_of_line;

    modport source (output valid, output haystack_byte, output end_of_line, input ready);
    modport sink   (input valid, input haystack_byte, input end_of_line, output ready);
endinterface

// ===== design/wasm_out_if.sv =====
interface wasm_out_if;
    import wasm_pkg::*;

    logic                valid;
    logic                ready;
    logic                found;
    logic [OFFSET_W-1:0] match_offset;
    logic                line_too_long;

    modport source (output valid, output found, output match_offset, output line_too_long,
                    input ready);
    modport sink   (input valid, input found, input match_offset, input line_too_long,
                    output ready);
endinterface

// ===== design/word_aware_substring_matcher.sv =====
// Word-aware substring matcher. Takes one line byte per cycle and reports, with
// the line's last byte, whether the configured needle (1 to MAX_NEEDLE_BYTES bytes,
// optional ASCII case folding, optional space-delimited whole-word rule) occurs,
// the offset of its first qualifying start in the original text, and whether the
// line ran past MAX_LINE_BYTES offsets. Throughput is one byte per cycle: a chain
// of window cells shifts the newest bytes along and compares all needle positions
// in the cycle the byte is accepted. The result leaves through an output register
// in the cycle after the end-of-line byte is accepted; input stalls only while that
// register holds a result the sink has not taken. Configuration writes take effect
// on the next accepted byte.
module word_aware_substring_matcher #(
    parameter int MAX_NEEDLE_BYTES = wasm_pkg::DEF_MAX_NEEDLE_BYTES,
    parameter int MAX_LINE_BYTES   = wasm_pkg::DEF_MAX_LINE_BYTES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    wasm_in_if.sink                         i_in,
    wasm_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [wasm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wasm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import wasm_pkg::*;

    localparam int N      = MAX_NEEDLE_BYTES;
    localparam int PW     = $clog2(MAX_LINE_BYTES);
    localparam int SEL_W  = $clog2(N + 1);
    localparam logic [PW-1:0] LAST_POS = PW'(MAX_LINE_BYTES - 1);

    // configuration
    logic [CFG_DATA_W-1:0] r_needle_low, r_needle_high;
    logic [LEN_W-1:0]      r_needle_len;
    logic [MODE_W-1:0]     r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_low  <= '0;
            r_needle_high <= '0;
            r_needle_len  <= LEN_W'(1);
            r_mode        <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_NEEDLE_LOW:  r_needle_low  <= i_cfg_data;
                CFG_NEEDLE_HIGH: r_needle_high <= i_cfg_data;
                CFG_NEEDLE_LEN:  r_needle_len  <= i_cfg_data[LEN_W-1:0];
                CFG_MATCH_MODE:  r_mode        <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // line state
    logic [PW-1:0] r_pos, n_pos;
    logic          r_ovf, n_ovf;
    logic          r_ms, n_ms;
    logic [PW-1:0] r_fo, n_fo;
    logic          r_pend, n_pend;
    logic [PW-1:0] r_pend_off, n_pend_off;

    logic                r_out_valid;
    logic                r_found;
    logic [OFFSET_W-1:0] r_off;
    logic                r_tl;

    logic              acc, eol, fold, whole;
    logic [BYTE_W-1:0] c;
    logic [LEN_W-1:0]  len_eff, len_m1;
    logic [PW-1:0]     len_m1x, start;
    logic              window_ok, hit, at_start, prior_space, qualify;
    logic              ms1;
    logic [PW-1:0]     fo1;

    logic [BYTE_W-1:0] needle_bytes [NEEDLE_SLOTS];
    logic [BYTE_W-1:0] chain [N+1];
    logic [N-1:0]      cell_match;
    t_cell_ctrl        cell_ctrl;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign acc   = i_in.valid && i_in.ready;
    assign c     = i_in.haystack_byte;
    assign eol   = i_in.end_of_line;
    assign fold  = r_mode[MODE_FOLD_BIT];
    assign whole = r_mode[MODE_WHOLE_BIT];

    assign cell_ctrl.shift = acc;
    assign cell_ctrl.clear = eol;
    assign cell_ctrl.fold  = fold;

    always_comb begin
        if (r_needle_len == '0) begin
            len_eff = LEN_W'(1);
        end else if (r_needle_len > LEN_W'(N)) begin
            len_eff = LEN_W'(N);
        end else begin
            len_eff = r_needle_len;
        end
    end
    assign len_m1  = len_eff - LEN_W'(1);
    assign len_m1x = PW'(len_m1);

    always_comb begin
        for (int k = 0; k < NEEDLE_SLOTS / 2; k++) begin
            needle_bytes[k]                    = r_needle_low[k*BYTE_W +: BYTE_W];
            needle_bytes[k + NEEDLE_SLOTS / 2] = r_needle_high[k*BYTE_W +: BYTE_W];
        end
    end

    assign chain[0] = c;

    // cell j sees the byte j places back; it meets needle byte len-1-j
    for (genvar j = 0; j < N; j++) begin : g_cell
        logic [LEN_W-1:0] slot;
        assign slot = len_eff - LEN_W'(j + 1);

        wasm_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (cell_ctrl),
            .i_active      (LEN_W'(j) < len_eff),
            .i_byte        (chain[j]),
            .i_needle_byte (needle_bytes[slot[SLOT_IDX_W-1:0]]),
            .o_byte        (chain[j+1]),
            .o_match       (cell_match[j])
        );
    end

    // byte just before the occurrence start
    assign prior_space = (chain[len_eff[SEL_W-1:0]] == SPACE_CHAR);

    always_comb begin
        // a pending whole-word candidate is settled by this byte
        ms1 = r_ms || (r_pend && c == SPACE_CHAR);
        fo1 = r_ms ? r_fo : r_pend_off;

        window_ok = r_ovf || (r_pos >= len_m1x);
        hit       = window_ok && (&cell_match);
        start     = r_ovf ? LAST_POS : r_pos - len_m1x;
        at_start  = !r_ovf && (r_pos == len_m1x);
        qualify   = at_start || prior_space;

        n_ms       = ms1;
        n_fo       = fo1;
        n_pend     = 1'b0;
        n_pend_off = r_pend_off;

        if (hit) begin
            if (!whole || (qualify && eol)) begin
                if (!ms1) begin
                    n_ms = 1'b1;
                    n_fo = start;
                end
            end else if (qualify && !ms1) begin
                n_pend     = 1'b1;
                n_pend_off = start;
            end
        end

        if (r_pos >= LAST_POS) begin
            n_ovf = 1'b1;
            n_pos = r_pos;
        end else begin
            n_ovf = r_ovf;
            n_pos = r_pos + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_ovf  <= 1'b0;
            r_ms   <= 1'b0;
            r_pend <= 1'b0;
        end else if (acc) begin
            if (eol) begin
                r_pos  <= '0;
                r_ovf  <= 1'b0;
                r_ms   <= 1'b0;
                r_pend <= 1'b0;
            end else begin
                r_pos  <= n_pos;
                r_ovf  <= n_ovf;
                r_ms   <= n_ms;
                r_pend <= n_pend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_fo       <= eol ? '0 : n_fo;
            r_pend_off <= eol ? '0 : n_pend_off;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (acc && eol) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && eol) begin
            r_found <= n_ms;
            r_off   <= n_ms ? OFFSET_W'(n_fo) : '0;
            r_tl    <= r_ovf;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.found         = r_found;
    assign o_out.match_offset  = r_off;
    assign o_out.line_too_long = r_tl;

`ifndef SYNTHESIS
    a_pend_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pend && r_ms))
        else $error("pending candidate alongside recorded match");

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_pos == LAST_POS))
        else $error("overflow without saturated offset");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while result beat is stalled");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && eol) |=> (r_pos == '0 && !r_ovf && !r_ms && !r_pend && r_out_valid))
        else $error("line state not cleared after end of line");

    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_found) |-> (r_off == '0))
        else $error("nonzero offset without a match");
`endif

endmodule

// ===== design/wasm_cell.sv =====
module wasm_cell (
    input  logic                       i_clk,
    input  wasm_pkg::t_cell_ctrl       i_ctrl,
    input  logic                       i_active,
    input  logic [wasm_pkg::BYTE_W-1:0] i_byte,
    input  logic [wasm_pkg::BYTE_W-1:0] i_needle_byte,
    output logic [wasm_pkg::BYTE_W-1:0] o_byte,
    output logic                       o_match
);
    import wasm_pkg::*;

    logic [BYTE_W-1:0] r_byte;
    logic [BYTE_W-1:0] n_byte;

    // window is wiped after the line-ending byte
    assign n_byte = i_ctrl.clear ? '0 : i_byte;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_byte <= n_byte;
        end
    end

    // compares the byte arriving at this slot this beat
    assign o_match = !i_active ||
                     (fold_byte(i_byte, i_ctrl.fold) == fold_byte(i_needle_byte, i_ctrl.fold));
    assign o_byte  = r_byte;

endmodule
